FILE: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// shared constants and types for the slot keyed feistel cipher pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

    localparam int unsigned ROUND_COUNT = 4;
    localparam int unsigned MIX_SHIFT   = 16;

    // pipeline depth: two key stages plus two stages per round
    localparam int unsigned PIPE_DEPTH  = 2 + 2 * ROUND_COUNT;

    localparam logic [31:0] MIX_MUL   = 32'h9E37_79B1;
    localparam logic [63:0] ROUND_MUL = 64'h517C_C1B7_2722_0A95;
    localparam logic [63:0] SLOT_MUL  = 64'h6A09_E667_F3BC_C908;
    localparam logic [31:0] SLOT_LO   = SLOT_MUL[31:0];
    localparam logic [31:0] SLOT_HI   = SLOT_MUL[63:32];

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [$clog2(ROUND_COUNT)-1:0] t_round;

    // round index times the round constant, mod 2^64
    localparam logic [63:0] ROUND_TAB [ROUND_COUNT] = '{
        64'd0,
        ROUND_MUL,
        64'(ROUND_MUL * 64'd2),
        64'(ROUND_MUL * 64'd3)
    };

    // x is the word fed to the round function, y the other word
    typedef struct packed {
        logic        vld;
        logic        dec;
        logic [31:0] x;
        logic [31:0] y;
        logic [63:0] skey;
    } t_stage;

endpackage

`default_nettype wire

FILE: rtl/sfc_req_if.sv
// ----------------------------------------------------------------------------
// sfc_req_if
// request channel: opcode, block and slot number with valid and ready
// ----------------------------------------------------------------------------
`default_nettype none

interface sfc_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] data_in;
    logic [31:0] slot_index;

    modport source (output valid, output opcode, output data_in, output slot_index,
                    input ready);
    modport sink   (input valid, input opcode, input data_in, input slot_index,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/sfc_rsp_if.sv
// ----------------------------------------------------------------------------
// sfc_rsp_if
// response channel: processed block with valid and ready
// ----------------------------------------------------------------------------
`default_nettype none

interface sfc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfc_key_gen.sv
// ----------------------------------------------------------------------------
// sfc_key_gen
// two stage slot key derivation: partial products, then sum and master xor
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_key_gen
    import sfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic        i_opcode,
    input  wire logic [63:0] i_data,
    input  wire logic [31:0] i_slot,
    input  wire logic [63:0] i_master_key,
    output t_stage           o_stage
);

    logic        r_vld1;
    logic        r_dec1;
    logic [31:0] r_x1;
    logic [31:0] r_y1;
    logic [63:0] r_pp_lo;
    logic [31:0] r_pp_hi;

    logic [31:0] n_x1;
    logic [31:0] n_y1;
    logic [63:0] n_pp_lo;
    logic [31:0] n_pp_hi;
    logic [63:0] n_skey;

    t_stage      r_out;

    // word routing: decrypt feeds the left word to the round function
    always_comb begin
        if (i_opcode == OP_DECRYPT) begin
            n_x1 = i_data[63:32];
            n_y1 = i_data[31:0];
        end else begin
            n_x1 = i_data[31:0];
            n_y1 = i_data[63:32];
        end
        n_pp_lo = {32'd0, i_slot} * {32'd0, SLOT_LO};
        n_pp_hi = i_slot * SLOT_HI;
    end

    // slot key from the two partial products
    assign n_skey = i_master_key ^ (r_pp_lo + {r_pp_hi, 32'd0});

    // stage registers, only the valid bits take the reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_vld1    <= i_valid;
            r_out.vld <= r_vld1;
        end
        if (i_en) begin
            r_dec1     <= i_opcode;
            r_x1       <= n_x1;
            r_y1       <= n_y1;
            r_pp_lo    <= n_pp_lo;
            r_pp_hi    <= n_pp_hi;
            r_out.dec  <= r_dec1;
            r_out.x    <= r_x1;
            r_out.y    <= r_y1;
            r_out.skey <= n_skey;
        end
    end

    assign o_stage = r_out;

endmodule

`default_nettype wire

FILE: rtl/sfc_round.sv
// ----------------------------------------------------------------------------
// sfc_round
// one feistel round in two stages: key xor and multiply, then fold and swap
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_round
    import sfc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_round i_round,
    input  wire t_stage i_stage,
    output t_stage      o_stage
);

    t_round      n_rnd;
    logic [63:0] n_t;
    logic [31:0] n_rk;
    logic [31:0] n_v;
    logic [31:0] n_f;

    t_stage      r_mid;
    logic [31:0] r_v;
    t_stage      r_out;

    // round key: reversed order when decrypting, high half folded on low
    always_comb begin
        n_rnd = (i_stage.dec == OP_DECRYPT) ? t_round'(ROUND_COUNT - 1) - i_round : i_round;
        n_t   = i_stage.skey ^ ROUND_TAB[n_rnd];
        n_rk  = n_t[63:32] ^ n_t[31:0];
        n_v   = (i_stage.x ^ n_rk) * MIX_MUL;
    end

    // mix fold and word swap
    assign n_f = r_v ^ (r_v >> MIX_SHIFT);

    // stage registers, only the valid bits take the reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.vld <= 1'b0;
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_mid.vld <= i_stage.vld;
            r_out.vld <= r_mid.vld;
        end
        if (i_en) begin
            r_mid.dec  <= i_stage.dec;
            r_mid.x    <= i_stage.x;
            r_mid.y    <= i_stage.y;
            r_mid.skey <= i_stage.skey;
            r_v        <= n_v;
            r_out.dec  <= r_mid.dec;
            r_out.x    <= r_mid.y ^ n_f;
            r_out.y    <= r_mid.x;
            r_out.skey <= r_mid.skey;
        end
    end

    assign o_stage = r_out;

endmodule

`default_nettype wire

FILE: rtl/slot_keyed_feistel_cipher_unit.sv
// ----------------------------------------------------------------------------
// slot_keyed_feistel_cipher_unit
// 4-round feistel cipher on 64-bit blocks under a per-slot key
// ----------------------------------------------------------------------------
// usage:
//   i_req carries opcode (0 encrypt, 1 decrypt), a 64-bit block and a 32-bit
//   slot number; o_rsp returns the processed block, one per request, in order.
//   i_cfg_wr_en / i_cfg_wr_data load the 64-bit master key; write it only
//   while no request is in flight.
// pipeline:
//   10 register stages: two key derivation stages (32x32 partial products,
//   then sum) and two stages per round (key xor and multiply, then fold and
//   swap). One request per cycle while the output is not stalled.
// reset:
//   synchronous, active low; clears all stage valid bits and the master key.
// stall:
//   the whole pipeline holds while o_rsp.valid is high and o_rsp.ready low;
//   i_req.ready drops for the same cycles, so nothing is lost or repeated.
//   Empty stages move along with the requests; they are not squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_keyed_feistel_cipher_unit
    import sfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [63:0] i_cfg_wr_data,
    sfc_req_if.sink          i_req,
    sfc_rsp_if.source        o_rsp
);

    logic [63:0] r_master_key;
    logic        n_en;
    t_stage      s_stage [ROUND_COUNT + 1];

    // master key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_key <= 64'd0;
        end else if (i_cfg_wr_en) begin
            r_master_key <= i_cfg_wr_data;
        end
    end

    // advance when the output stage is empty or being taken
    assign n_en        = !s_stage[ROUND_COUNT].vld || o_rsp.ready;
    assign i_req.ready = n_en;

    sfc_key_gen u_key_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (n_en),
        .i_valid      (i_req.valid),
        .i_opcode     (i_req.opcode),
        .i_data       (i_req.data_in),
        .i_slot       (i_req.slot_index),
        .i_master_key (r_master_key),
        .o_stage      (s_stage[0])
    );

    // round chain
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        sfc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_round (t_round'(g)),
            .i_stage (s_stage[g]),
            .o_stage (s_stage[g + 1])
        );
    end

    // output: undo the word routing chosen at entry
    assign o_rsp.valid    = s_stage[ROUND_COUNT].vld;
    assign o_rsp.data_out = (s_stage[ROUND_COUNT].dec == OP_DECRYPT)
                          ? {s_stage[ROUND_COUNT].x, s_stage[ROUND_COUNT].y}
                          : {s_stage[ROUND_COUNT].y, s_stage[ROUND_COUNT].x};

endmodule

`default_nettype wire

FILE: rtl/sfc_checker.sv
// ----------------------------------------------------------------------------
// sfc_checker
// port level checks on request and response channels of the cipher unit
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_checker
    import sfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_ready,
    input  wire logic [63:0] i_rsp_data
);

    localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             n_acc;
    logic             n_dlv;

    assign n_acc = i_req_valid && i_req_ready;
    assign n_dlv = i_rsp_valid && i_rsp_ready;

    // requests in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(n_acc) - CNT_W'(n_dlv);
        end
    end

    // stalled response holds its data
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response changed while stalled");

    // no response without an outstanding request
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_cnt != '0)
        else $error("response without request");

    // in-flight count bounded by pipeline depth
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // an empty output stage never blocks a request
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request blocked with empty output");

endmodule

bind slot_keyed_feistel_cipher_unit sfc_checker u_sfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data_out)
);

`default_nettype wire
